// File: hdl/bsrt_pkg.sv
// Shared types and codes for the backing store region table.
package bsrt_pkg;

    // Operation kinds carried in the input word's tuser.
    localparam logic [1:0] K_FIND   = 2'd0;
    localparam logic [1:0] K_FREE   = 2'd1;
    localparam logic [1:0] K_LOOKUP = 2'd2;
    localparam logic [1:0] K_MAP    = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_FREE    = 3'd1;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd2;
    localparam logic [2:0] ST_OUTSIDE    = 3'd3;
    localparam logic [2:0] ST_REJECTED   = 3'd4;

    localparam int BASE_W  = 20;
    localparam int PAGES_W = 9;
    localparam int OWNER_W = 6;

    // One stored range: base page and page count.
    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
    } t_range;

    // Directory update request.
    typedef struct packed {
        logic set_en;
        logic clr_en;
    } t_dir_cmd;

    // Directory search flags.
    typedef struct packed {
        logic free_hit;
        logic own_hit;
        logic sel_mapped;
    } t_dir_res;

endpackage

// File: hdl/backing_store_region_table_unit.sv
// Top level of the backing store region table.
//
// One input word on the s_axis channel carries an operation (tuser) and its
// operands (tdata); each produces exactly one result word on m_axis.
// Operations: find the lowest free store, free a store, map a store to an
// owner and page range, or look up a virtual address for an owner.
// Mapped flags and owners sit in flip-flops and are searched in parallel;
// base page and page count sit in a synchronous memory with a registered read.
// Find, free and map pass from acceptance through the execute state to a
// result in the output register; lookup adds a compare state after it, the
// extra step being the memory read of the chosen store's range. One item is
// in flight at a time, so no new word is taken until the last result is registered.
// The output register lets a new word be accepted while a result waits.
// If m_axis stalls, the finished operation holds before committing, so the
// table is updated exactly once per word.
// Reset clears every mapped flag; owners and ranges are rewritten by a map
// before they are ever read, so no clearing pass is needed.
module backing_store_region_table_unit
    import bsrt_pkg::*;
#(
    parameter int NUM_STORES  = 8,
    parameter int STORE_PAGES = 256,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // store_sel[2:0], owner_id[8:3], virt_addr[40:9], base_page[60:41],
    // page_count[69:61], zero pad[71:70]
    input  logic [71:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], store_found[5:3], page_offset[13:6], zero pad[15:14]
    output logic [15:0] m_axis_tdata
);

    localparam int IW  = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
    localparam int PSH = $clog2(PAGE_BYTES);
    localparam int CW  = 34;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_kind;
    logic [2:0]         r_sel;
    logic [OWNER_W-1:0] r_owner;
    logic [31:0]        r_vaddr;
    logic [BASE_W-1:0]  r_base;
    logic [PAGES_W-1:0] r_count;
    logic [IW-1:0]      r_pick;
    logic               r_own_hit;
    logic               r_m_valid, n_m_valid;
    logic [15:0]        r_m_data, n_m_data;

    t_dir_cmd      dir_cmd;
    t_dir_res      dir_res;
    logic [IW-1:0] sel_idx;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] own_idx;
    logic          sel_in_range;
    logic          count_ok;
    logic          out_free;
    logic          ram_we;
    logic          ram_re;
    t_range        ram_wdata;
    t_range        ram_rdata;
    logic [6:0]    sel_ext;
    logic [CW-1:0] page_w;
    logic [CW-1:0] lo_w;
    logic [CW-1:0] hi_w;
    logic [CW-1:0] off_w;
    logic          in_range;
    logic [6:0]    pick_ext;
    logic [6:0]    free_ext;

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_m_valid || m_axis_tready;

    assign sel_ext      = {4'd0, r_sel};
    assign sel_idx      = sel_ext[IW-1:0];
    assign sel_in_range = sel_ext < 7'(NUM_STORES);
    assign count_ok     = (r_count != '0) && (13'(r_count) <= 13'(STORE_PAGES));
    assign pick_ext     = 7'(r_pick);
    assign free_ext     = 7'(free_idx);

    bsrt_dir #(
        .NUM (NUM_STORES),
        .IW  (IW)
    ) u_dir (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dir_cmd),
        .i_sel      (sel_idx),
        .i_owner    (r_owner),
        .o_res      (dir_res),
        .o_free_idx (free_idx),
        .o_own_idx  (own_idx)
    );

    assign ram_wdata.base  = r_base;
    assign ram_wdata.pages = r_count;

    bsrt_ram #(
        .DEPTH (NUM_STORES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (sel_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (own_idx),
        .o_rdata (ram_rdata)
    );

    // Range check, widened so base + pages cannot wrap.
    assign page_w   = CW'(r_vaddr >> PSH);
    assign lo_w     = CW'(ram_rdata.base);
    assign hi_w     = lo_w + CW'(ram_rdata.pages);
    assign in_range = (page_w >= lo_w) && (page_w < hi_w);
    assign off_w    = page_w - lo_w;

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        dir_cmd   = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_kind == K_LOOKUP) begin
                    ram_re  = 1'b1;
                    n_state = S_CMP;
                end else if (out_free) begin
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                    n_m_data  = {13'd0, ST_OK};
                    case (r_kind)
                        K_FIND: begin
                            if (dir_res.free_hit) begin
                                n_m_data = {10'd0, free_ext[2:0], ST_OK};
                            end else begin
                                n_m_data = {13'd0, ST_NO_FREE};
                            end
                        end
                        K_FREE: begin
                            dir_cmd.clr_en = sel_in_range;
                        end
                        K_MAP: begin
                            if (sel_in_range && !dir_res.sel_mapped && count_ok) begin
                                dir_cmd.set_en = 1'b1;
                                ram_we         = 1'b1;
                            end else begin
                                n_m_data = {13'd0, ST_REJECTED};
                            end
                        end
                        default: begin
                            n_m_data = {13'd0, ST_OK};
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                    if (!r_own_hit) begin
                        n_m_data = {13'd0, ST_NOT_MAPPED};
                    end else if (in_range) begin
                        n_m_data = {2'd0, off_w[7:0], pick_ext[2:0], ST_OK};
                    end else begin
                        n_m_data = {10'd0, pick_ext[2:0], ST_OUTSIDE};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind  <= s_axis_tuser;
            r_sel   <= s_axis_tdata[2:0];
            r_owner <= s_axis_tdata[8:3];
            r_vaddr <= s_axis_tdata[40:9];
            r_base  <= s_axis_tdata[60:41];
            r_count <= s_axis_tdata[69:61];
        end
        if (r_state == S_EXEC) begin
            r_pick    <= own_idx;
            r_own_hit <= dir_res.own_hit;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// File: hdl/bsrt_ram.sv
// Range memory: base page and page count of each store, registered read.
module bsrt_ram
    import bsrt_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_range        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_range        o_rdata
);

    t_range r_mem [DEPTH];
    t_range r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so a stalled result stays intact.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bsrt_dir.sv
// Store directory: mapped flags and owners with priority search.
module bsrt_dir
    import bsrt_pkg::*;
#(
    parameter int NUM = 8,
    parameter int IW  = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dir_cmd           i_cmd,
    input  logic [IW-1:0]      i_sel,
    input  logic [OWNER_W-1:0] i_owner,
    output t_dir_res           o_res,
    output logic [IW-1:0]      o_free_idx,
    output logic [IW-1:0]      o_own_idx
);

    logic [NUM-1:0]     r_mapped;
    logic [OWNER_W-1:0] r_owner [NUM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped <= '0;
        end else if (i_cmd.set_en) begin
            r_mapped[i_sel] <= 1'b1;
        end else if (i_cmd.clr_en) begin
            r_mapped[i_sel] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_en) begin
            r_owner[i_sel] <= i_owner;
        end
    end

    // Lowest index wins: scan from the top so lower entries overwrite.
    always_comb begin
        o_res.free_hit = 1'b0;
        o_res.own_hit  = 1'b0;
        o_free_idx     = '0;
        o_own_idx      = '0;
        for (int k = NUM - 1; k >= 0; k--) begin
            if (!r_mapped[k]) begin
                o_res.free_hit = 1'b1;
                o_free_idx     = IW'(k);
            end
            if (r_mapped[k] && (r_owner[k] == i_owner)) begin
                o_res.own_hit = 1'b1;
                o_own_idx     = IW'(k);
            end
        end
        o_res.sel_mapped = r_mapped[i_sel];
    end

endmodule
